// ===== hdl/rbd_pkg.sv =====
// Shared types, codes and constants of the run-length byte decoder.
package rbd_pkg;

   localparam int unsigned LEN_W       = 12;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LIT_W       = 7;
   localparam int unsigned MAX_LEN_DEF = 2048;
   localparam int unsigned QUEUE_DEPTH = 2;

   // Stream action codes carried in req_tuser
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_FEED  = 2'd1;
   localparam logic [1:0] ACT_PULL  = 2'd2;

   // Result status codes carried in rsp_tuser
   localparam logic [1:0] ST_BYTE    = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_MISUSE  = 2'd2;
   localparam logic [1:0] ST_OVERRUN = 2'd3;

   localparam logic [BYTE_W-1:0] ZERO_PACKET_HDR = 8'h80;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_FEED,
      KIND_PULL,
      KIND_IDLE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [BYTE_W-1:0]  data;
      logic [LEN_W-1:0]   length;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [1:0]         status;
      logic               last;
      logic               run_pending;
   } rsp_type;

endpackage

// ===== hdl/rbd_front.sv =====
// Front end: classify an incoming beat and clamp the packet length.
module rbd_front #(
   parameter int unsigned MAX_PACKET_LENGTH = rbd_pkg::MAX_LEN_DEF
) (
   input  logic [1:0]                 action,
   input  logic [rbd_pkg::BYTE_W-1:0] in_byte,
   input  logic [rbd_pkg::LEN_W-1:0]  packet_length,
   output rbd_pkg::cmd_type           cmd
);

   always_comb begin
      cmd.data   = in_byte;
      cmd.length = packet_length;
      // Clamp lengths above the configured maximum
      if (32'(packet_length) > MAX_PACKET_LENGTH) begin
         cmd.length = rbd_pkg::LEN_W'(MAX_PACKET_LENGTH);
      end
      case (action)
         rbd_pkg::ACT_START: cmd.kind = rbd_pkg::KIND_START;
         rbd_pkg::ACT_FEED:  cmd.kind = rbd_pkg::KIND_FEED;
         rbd_pkg::ACT_PULL:  cmd.kind = rbd_pkg::KIND_PULL;
         default:            cmd.kind = rbd_pkg::KIND_IDLE;
      endcase
   end

endmodule

// ===== hdl/rbd_queue.sv =====
// Short command queue between the front and back ends.
module rbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbd_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output rbd_pkg::cmd_type pop_cmd
);

   localparam int unsigned PTR_W = (rbd_pkg::QUEUE_DEPTH > 1) ? $clog2(rbd_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(rbd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rbd_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rbd_pkg::QUEUE_DEPTH);

   rbd_pkg::cmd_type   slot_ff [rbd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign not_full  = (count_ff != FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/rbd_back.sv =====
// Back end: decoder state, byte emission and the result register.
module rbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rbd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_taken,
   output rbd_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RUNVAL,
      PH_LITERAL
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic                        first_ff, first_in;
   logic [rbd_pkg::LIT_W-1:0]   lit_left_ff, lit_left_in;
   logic [rbd_pkg::BYTE_W-1:0]  run_value_ff, run_value_in;
   logic [rbd_pkg::LEN_W-1:0]   run_left_ff, run_left_in;
   logic [rbd_pkg::LEN_W-1:0]   produced_ff, produced_in;
   logic [rbd_pkg::LEN_W-1:0]   target_ff, target_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rbd_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        room;
   logic [rbd_pkg::LEN_W-1:0]   produced_inc;
   logic                        emit_ok;
   logic [rbd_pkg::LIT_W-1:0]   lit_dec;

   assign room         = !rsp_valid_ff || rsp_taken;
   assign cmd_pop      = cmd_valid && room;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;
   assign produced_inc = produced_ff + 1'b1;
   assign emit_ok      = (produced_ff < target_ff);

   always_comb begin
      phase_in     = phase_ff;
      first_in     = first_ff;
      lit_left_in  = lit_left_ff;
      run_value_in = run_value_ff;
      run_left_in  = run_left_ff;
      produced_in  = produced_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      lit_dec      = (lit_left_ff != '0) ? lit_left_ff - 1'b1 : lit_left_ff;

      if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd_pop) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = '0;
         rsp_in.status      = rbd_pkg::ST_NONE;
         rsp_in.last        = 1'b0;

         case (cmd.kind)
            rbd_pkg::KIND_START: begin
               target_in    = cmd.length;
               phase_in     = PH_HEADER;
               first_in     = 1'b1;
               lit_left_in  = '0;
               run_value_in = '0;
               run_left_in  = '0;
               produced_in  = '0;
            end
            rbd_pkg::KIND_FEED: begin
               if (run_left_ff != '0) begin
                  rsp_in.status = rbd_pkg::ST_MISUSE;
               end else if (phase_ff == PH_RUNVAL) begin
                  // Value byte of a run: load the pending run
                  run_value_in = cmd.data;
                  run_left_in  = rbd_pkg::LEN_W'(lit_left_ff);
                  lit_left_in  = '0;
                  phase_in     = PH_HEADER;
               end else if (phase_ff == PH_LITERAL) begin
                  if (emit_ok) begin
                     produced_in     = produced_inc;
                     rsp_in.status   = rbd_pkg::ST_BYTE;
                     rsp_in.out_byte = cmd.data;
                     rsp_in.last     = (produced_inc == target_ff);
                  end else begin
                     rsp_in.status = rbd_pkg::ST_OVERRUN;
                  end
                  lit_left_in = lit_dec;
                  if (lit_dec == '0) begin
                     phase_in = PH_HEADER;
                  end
               end else begin
                  // Header byte
                  if (first_ff && cmd.data == rbd_pkg::ZERO_PACKET_HDR) begin
                     run_value_in = '0;
                     run_left_in  = target_ff - produced_ff;
                  end else if (cmd.data[rbd_pkg::BYTE_W-1]) begin
                     lit_left_in = cmd.data[rbd_pkg::LIT_W-1:0];
                     phase_in    = PH_RUNVAL;
                  end else if (cmd.data != '0) begin
                     lit_left_in = cmd.data[rbd_pkg::LIT_W-1:0];
                     phase_in    = PH_LITERAL;
                  end
                  first_in = 1'b0;
               end
            end
            rbd_pkg::KIND_PULL: begin
               if (run_left_ff == '0) begin
                  rsp_in.status = rbd_pkg::ST_MISUSE;
               end else begin
                  run_left_in = run_left_ff - 1'b1;
                  if (emit_ok) begin
                     produced_in     = produced_inc;
                     rsp_in.status   = rbd_pkg::ST_BYTE;
                     rsp_in.out_byte = run_value_ff;
                     rsp_in.last     = (produced_inc == target_ff);
                  end else begin
                     rsp_in.status = rbd_pkg::ST_OVERRUN;
                  end
               end
            end
            default: begin
            end
         endcase

         rsp_in.run_pending = (run_left_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         first_ff     <= 1'b1;
         lit_left_ff  <= '0;
         run_value_ff <= '0;
         run_left_ff  <= '0;
         produced_ff  <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         lit_left_ff  <= lit_left_in;
         run_value_ff <= run_value_in;
         run_left_ff  <= run_left_in;
         produced_ff  <= produced_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== hdl/rle_byte_decoder.sv =====
// Top level of the run-length byte decoder: front end, command queue, back end.
//
//  channel | dir | tdata (low bit up)                         | tuser      | tlast
//  req_    | in  | in_byte[7:0], packet_length[19:8], pad     | action     | -
//  rsp_    | out | out_byte[7:0], run_pending[8], pad         | status     | last
//
// One beat in, one beat out, one beat per cycle sustained while rsp_ does not stall;
// the back end's registered state update sets the rate. rsp_tvalid rises once an
// accepted req beat has passed the queue slot register and then the back end's result
// register; older queued beats or a stall on rsp_ can hold it between the two.
// Reset is synchronous and clears the queue, the decoder state and rsp_tvalid.
// A stall on rsp_ holds the result register; req_ keeps taking beats until the
// two-entry queue fills, then req_tready drops.
module rle_byte_decoder #(
   parameter int unsigned MAX_PACKET_LENGTH = rbd_pkg::MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] in_byte, [19:8] packet_length, [23:20] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] run_pending, [15:9] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last byte of the packet
);

   rbd_pkg::cmd_type front_cmd;
   rbd_pkg::cmd_type queue_cmd;
   rbd_pkg::rsp_type back_rsp;
   logic             queue_not_full;
   logic             queue_not_empty;
   logic             queue_pop;
   logic             back_valid;

   // Classify the beat and clamp its length
   rbd_front #(
      .MAX_PACKET_LENGTH(MAX_PACKET_LENGTH)
   ) u_front (
      .action        (req_tuser),
      .in_byte       (req_tdata[7:0]),
      .packet_length (req_tdata[19:8]),
      .cmd           (front_cmd)
   );

   // Decouple acceptance from execution
   rbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_cmd  (front_cmd),
      .not_full  (queue_not_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_cmd   (queue_cmd)
   );

   assign req_tready = queue_not_full;

   // Execute commands and hold the result beat
   rbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .rsp_valid (back_valid),
      .rsp_taken (rsp_tready),
      .rsp       (back_rsp)
   );

   assign rsp_tvalid = back_valid;
   assign rsp_tdata  = {7'd0, back_rsp.run_pending, back_rsp.out_byte};
   assign rsp_tuser  = back_rsp.status;
   assign rsp_tlast  = back_rsp.last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for rle_byte_decoder: directed and random streams.
module tb_top;

   // Action code that the block must treat as a no-op.
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam int unsigned MAX_LEN      = rbd_pkg::MAX_LEN_DEF;
   localparam int unsigned RANDOM_BEATS = 1550;
   localparam int unsigned CALM_BEATS   = 200;     // final stretch without idling
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned REPORT_MAX   = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] in_byte, [19:8] packet_length, [23:20] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;         // [7:0] out_byte, [8] run_pending, [15:9] zero
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        rsp_tlast;

   rle_byte_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Decoder state as the testbench sees it
   // ---------------------------------------------------------------------
   typedef enum logic [1:0] {
      SEEK_HEADER,
      SEEK_VALUE,
      COPY_LITERAL
   } parse_state_type;

   parse_state_type parse_state = SEEK_HEADER;
   logic         first_pending = 1'b1;   // next fed byte opens the packet
   logic [6:0]   lit_left      = '0;     // literal bytes left, or run count awaiting value
   logic [7:0]   rep_value     = '0;
   logic [11:0]  rep_left      = '0;
   logic [11:0]  produced      = '0;
   logic [11:0]  target        = '0;

   rbd_pkg::rsp_type decode_due[$];      // results owed by the block, oldest first
   int unsigned beats_sent    = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;
   bit          quiet         = 1'b0;    // set: no gaps, no stalls
   int unsigned src_gap_odds  = 4;       // 0 disables sender gaps
   int unsigned sink_gap_odds = 6;       // 0 disables receiver stalls

   // Count one decoded byte against the packet length; flag overrun past it.
   function automatic logic [1:0] count_out(output logic fin);
      fin = 1'b0;
      if (produced >= target)
         return rbd_pkg::ST_OVERRUN;
      produced = produced + 12'd1;
      fin = (produced == target);
      return rbd_pkg::ST_BYTE;
   endfunction

   // Advance the decoder state by one beat and return the result it owes.
   function automatic rbd_pkg::rsp_type decode_step(logic [1:0] act, logic [7:0] b,
                                                    logic [11:0] plen);
      rbd_pkg::rsp_type r;
      logic    fin;
      r        = '0;
      r.status = rbd_pkg::ST_NONE;
      fin      = 1'b0;
      case (act)
         rbd_pkg::ACT_START: begin
            target        = (plen > MAX_LEN) ? 12'(MAX_LEN) : plen;
            parse_state   = SEEK_HEADER;
            first_pending = 1'b1;
            lit_left      = '0;
            rep_value     = '0;
            rep_left      = '0;
            produced      = '0;
         end
         rbd_pkg::ACT_FEED: begin
            if (rep_left != 0) begin
               r.status = rbd_pkg::ST_MISUSE;
            end else begin
               case (parse_state)
                  SEEK_VALUE: begin
                     rep_value   = b;
                     rep_left    = {5'd0, lit_left};
                     lit_left    = '0;
                     parse_state = SEEK_HEADER;
                  end
                  COPY_LITERAL: begin
                     r.status = count_out(fin);
                     if (r.status == rbd_pkg::ST_BYTE)
                        r.out_byte = b;
                     if (lit_left != 0)
                        lit_left = lit_left - 7'd1;
                     if (lit_left == 0)
                        parse_state = SEEK_HEADER;
                  end
                  default: begin
                     // A zero-packet marker only counts as the packet's first byte.
                     if (first_pending && b == rbd_pkg::ZERO_PACKET_HDR) begin
                        rep_value = '0;
                        rep_left  = target - produced;
                     end else if (b[7]) begin
                        lit_left    = b[6:0];
                        parse_state = SEEK_VALUE;
                     end else if (b != 0) begin
                        lit_left    = b[6:0];
                        parse_state = COPY_LITERAL;
                     end
                     first_pending = 1'b0;
                  end
               endcase
            end
         end
         rbd_pkg::ACT_PULL: begin
            if (rep_left == 0) begin
               r.status = rbd_pkg::ST_MISUSE;
            end else begin
               rep_left = rep_left - 12'd1;
               r.status = count_out(fin);
               if (r.status == rbd_pkg::ST_BYTE)
                  r.out_byte = rep_value;
            end
         end
         default: ;
      endcase
      r.last        = fin;
      r.run_pending = (rep_left != 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one beat per call, with an optional gap in front of it
   // ---------------------------------------------------------------------
   task automatic send_beat(logic [1:0] act, logic [7:0] b, logic [11:0] plen);
      if (!quiet && src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tdata  = {4'd0, plen, b};
      req_tuser  = act;
      req_tvalid = 1'b1;
      // Hold the beat until the block takes it.
      do @(posedge clock); while (!req_tready);
      decode_due.push_back(decode_step(act, b, plen));
      beats_sent++;
      @(negedge clock);
   endtask

   // Fill the fields the action ignores with random values.
   task automatic start_packet(logic [11:0] plen);
      send_beat(rbd_pkg::ACT_START, 8'($urandom), plen);
   endtask

   task automatic feed(logic [7:0] b);
      send_beat(rbd_pkg::ACT_FEED, b, 12'($urandom));
   endtask

   task automatic pull();
      send_beat(rbd_pkg::ACT_PULL, 8'($urandom), 12'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stall in random bursts of whole cycles
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && sink_gap_odds != 0 && $urandom_range(1, sink_gap_odds) == 1) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: compare every accepted result beat with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rbd_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decode_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result beat: byte %02h status %0d last %b pending %b",
                        rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[8]);
         end else begin
            want = decode_due.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte || rsp_tuser !== want.status ||
                rsp_tlast !== want.last || rsp_tdata[8] !== want.run_pending) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"result beat differs: expected byte %02h status %0d last %b ",
                            "pending %b, got byte %02h status %0d last %b pending %b"},
                           want.out_byte, want.status, want.last, want.run_pending,
                           rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[8]);
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rle_byte_decoder: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Literal headers: empty literal, then extreme byte values passed through.
   task automatic test_literal_copy();
      start_packet(12'd6);
      feed(8'h00);
      feed(8'h02);
      feed(8'h00);
      feed(8'hFF);
   endtask

   // Runs: saturated length, feed during a run, pull past the run, empty run.
   task automatic test_run_pull();
      start_packet(12'hFFF);
      feed(8'h82);
      feed(8'hAA);
      feed(8'h11);
      pull();
      pull();
      pull();
      feed(8'h80);        // not the first byte: run of count zero
      feed(8'h55);
      pull();
   endtask

   // Zero packet: a leading marker makes the whole packet zeros via pulls.
   task automatic test_zero_packet();
      start_packet(12'd2);
      feed(rbd_pkg::ZERO_PACKET_HDR);
      pull();
      pull();
   endtask

   // Overrun on zero and short lengths, restart mid-run, spare action.
   task automatic test_overrun_restart();
      start_packet(12'd0);
      feed(8'h01);
      feed(8'h12);
      start_packet(12'd1);
      feed(8'hFF);
      feed(8'hC3);
      pull();
      pull();
      start_packet(12'd2048);
      pull();
      send_beat(ACT_SPARE, 8'($urandom), 12'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Random packets: mostly well-formed segments with random content,
   // mixed with noise beats and broken sequences
   // ---------------------------------------------------------------------
   task automatic test_random_stream();
      int unsigned stop_at;
      int unsigned plen;
      int unsigned eff;
      int unsigned segs;
      int unsigned n;
      int unsigned k;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         if (beats_sent + CALM_BEATS >= stop_at)
            quiet = 1'b1;
         // Vary idling per packet, with some packets free of it.
         src_gap_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
         sink_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);

         k = $urandom_range(0, 19);
         if (k == 0)
            plen = 0;
         else if (k == 1)
            plen = $urandom_range(0, 4095);
         else
            plen = $urandom_range(1, 48);
         start_packet(12'(plen));
         eff = (plen > MAX_LEN) ? MAX_LEN : plen;

         // Zero packet, drained by pulls; cap the pulls on long packets.
         if ($urandom_range(0, 5) == 0) begin
            feed(rbd_pkg::ZERO_PACKET_HDR);
            n = (eff > 64) ? $urandom_range(1, 64) : eff + $urandom_range(0, 1);
            repeat (n) pull();
         end

         segs = $urandom_range(1, 8);
         repeat (segs) begin
            k = $urandom_range(0, 9);
            if (k < 4) begin
               // Literal segment, now and then cut short.
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
               feed(8'(n));
               if (n > 0 && $urandom_range(0, 7) == 0)
                  n = $urandom_range(0, n - 1);
               repeat (n) feed(8'($urandom));
            end else if (k < 8) begin
               // Run segment; pull one too few or one too many at times.
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
               feed(8'h80 | 8'(n));
               feed(8'($urandom));
               k = $urandom_range(0, 9);
               if (k == 0 && n > 0)
                  n = n - 1;
               else if (k == 1)
                  n = n + 1;
               repeat (n) pull();
            end else begin
               // Noise: any action but start, with random fields.
               repeat ($urandom_range(1, 3))
                  send_beat(2'($urandom_range(1, 3)), 8'($urandom), 12'($urandom));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_literal_copy();
      test_run_pull();
      test_zero_packet();
      test_overrun_restart();
      test_random_stream();
      req_tvalid = 1'b0;

      // Drain: wait for every owed result, then keep watching for strays.
      while (decode_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && decode_due.size() == 0)
         $display("rle_byte_decoder: match");
      else
         $display("rle_byte_decoder: mismatch");
      $finish;
   end

endmodule
